// ===== design/rtbep_pkg.sv =====
package rtbep_pkg;

  // Field widths
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned SEQ_BITS  = 16;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned IVAL_W    = 16;
  localparam int unsigned OFS_W     = 8;

  // Stream payload widths (packed fields rounded up to whole bytes)
  localparam int unsigned IN_FIELDS_W  = TIME_BITS + SEQ_BITS + SLOT_W + 2;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = SEQ_BITS + SLOT_W + 1;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_PICK      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ACK_START = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ACK_STOP  = 3'd4;

  // Event codes
  localparam logic [CODE_W-1:0] EV_NONE      = 3'd0;
  localparam logic [CODE_W-1:0] EV_ACK_TMO   = 3'd1;
  localparam logic [CODE_W-1:0] EV_FRAME     = 3'd2;
  localparam logic [CODE_W-1:0] EV_NET_READY = 3'd3;
  localparam logic [CODE_W-1:0] EV_DATA_TMO  = 3'd4;

  localparam logic [IVAL_W-1:0] IVAL_RESET = 16'd100;
  localparam logic [OFS_W-1:0]  OFS_MAX    = 8'hFF;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [TIME_BITS-1:0] now;
    logic [SEQ_BITS-1:0]  seq_number;
    logic [SLOT_W-1:0]    slot_index;
    logic                 frame_waiting;
    logic                 net_ready;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0]   event_code;
    logic [SEQ_BITS-1:0] expired_seq;
    logic [SLOT_W-1:0]   expired_slot;
    logic                stop_missed;
  } res_t;

  // Add two times, clamping at the all-ones time
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

endpackage

// ===== design/retransmit_timer_bank_event_picker.sv =====
// A request is loaded into the request register when accepted and its result into
//   the result register once that register is free (result stream ready or empty).
// Throughput: one request per cycle while results are taken; slot compare, deadline
//   add and the min tree over the slot bank settle combinationally between those registers.
// Reset: all slot and ack timers off, slot tags all ones, start offset and
//   earliest deadline zero, timeout interval 100.
module retransmit_timer_bank_event_picker
  import rtbep_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration: retransmit interval in ticks
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IVAL_W-1:0]     cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // now[31:0], seq_number[47:32], slot_index[50:48], frame_waiting[51],
  // net_ready[52], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[2:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // expired_seq[15:0], expired_slot[18:16], stop_missed[19], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // event_code[2:0]
  output logic [CODE_W-1:0]     m_axis_tuser
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LEAVES = 1 << IDX_W;

  // Pipeline registers
  logic s0_valid_q, out_valid_q;
  req_t req_q;
  res_t res_q, res_d;
  logic advance, fire;

  // Timer state
  logic [TIME_BITS-1:0] dl_q [SLOTS];
  logic [TIME_BITS-1:0] dl_d [SLOTS];
  logic [SEQ_BITS-1:0]  tag_q [SLOTS];
  logic [SEQ_BITS-1:0]  tag_d [SLOTS];
  logic [TIME_BITS-1:0] ack_q, ack_d;
  logic [TIME_BITS-1:0] earliest_q, earliest_d;
  logic [OFS_W-1:0]     ofs_q, ofs_d;
  logic [IVAL_W-1:0]    ival_q;

  // Datapath intermediates
  logic                 recompute;
  logic                 exp_hit, stop_hit, slot_ok;
  logic [IDX_W-1:0]     exp_idx, stop_idx, start_idx;
  logic [SLOT_W-1:0]    exp_slot;
  logic [TIME_BITS-1:0] start_dl, ack_start_dl;
  logic [OFS_W-1:0]     ofs_bump;
  logic [TIME_BITS-1:0] tree [1:2*LEAVES-1];

  // Handshake: the request stage moves on when the result register is free
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = s0_valid_q && advance;
  assign s_axis_tready = !s0_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.event_code;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, res_q.stop_missed,
                          res_q.expired_slot, res_q.expired_seq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s0_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= s0_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q.mode          <= s_axis_tuser;
      req_q.now           <= s_axis_tdata[TIME_BITS-1:0];
      req_q.seq_number    <= s_axis_tdata[TIME_BITS+SEQ_BITS-1:TIME_BITS];
      req_q.slot_index    <= s_axis_tdata[TIME_BITS+SEQ_BITS+SLOT_W-1:TIME_BITS+SEQ_BITS];
      req_q.frame_waiting <= s_axis_tdata[TIME_BITS+SEQ_BITS+SLOT_W];
      req_q.net_ready     <= s_axis_tdata[TIME_BITS+SEQ_BITS+SLOT_W+1];
    end
    if (fire) res_q <= res_d;
  end

  // Timer state and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        dl_q[i]  <= '0;
        tag_q[i] <= '1;
      end
      ack_q      <= '0;
      earliest_q <= '0;
      ofs_q      <= '0;
      ival_q     <= IVAL_RESET;
    end else begin
      if (fire) begin
        for (int i = 0; i < SLOTS; i++) begin
          dl_q[i]  <= dl_d[i];
          tag_q[i] <= tag_d[i];
        end
        ack_q      <= ack_d;
        earliest_q <= earliest_d;
        ofs_q      <= ofs_d;
      end
      if (cfg_valid_i) ival_q <= cfg_data_i;
    end
  end

  // Lowest live slot at the earliest deadline, and lowest slot with a matching tag
  always_comb begin
    exp_hit  = 1'b0;
    exp_idx  = '0;
    exp_slot = '0;
    stop_hit = 1'b0;
    stop_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (dl_q[i] != '0 && dl_q[i] == earliest_q) begin
        exp_hit  = 1'b1;
        exp_idx  = IDX_W'(i);
        exp_slot = SLOT_W'(i);
      end
      if (tag_q[i] == req_q.seq_number) begin
        stop_hit = 1'b1;
        stop_idx = IDX_W'(i);
      end
    end
  end

  assign slot_ok      = 32'(req_q.slot_index) < SLOTS;
  assign start_idx    = IDX_W'(req_q.slot_index);
  assign start_dl     = sat_add(sat_add(req_q.now, TIME_BITS'(ival_q)), TIME_BITS'(ofs_q));
  assign ack_start_dl = sat_add(req_q.now, TIME_BITS'(ival_q >> 1));
  assign ofs_bump     = (ofs_q == OFS_MAX) ? ofs_q : ofs_q + 1'b1;

  // Command decode and next state
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      dl_d[i]  = dl_q[i];
      tag_d[i] = tag_q[i];
    end
    ack_d     = ack_q;
    ofs_d     = ofs_q;
    recompute = 1'b0;
    res_d     = '0;
    case (req_q.mode)
      MODE_PICK: begin
        ofs_d = '0;
        if (ack_q != '0 && req_q.now >= ack_q) begin
          ack_d            = '0;
          res_d.event_code = EV_ACK_TMO;
        end else if (req_q.frame_waiting) begin
          res_d.event_code = EV_FRAME;
        end else if (req_q.net_ready) begin
          res_d.event_code = EV_NET_READY;
        end else if (earliest_q != '0 && req_q.now >= earliest_q && exp_hit) begin
          dl_d[exp_idx]      = '0;
          recompute          = 1'b1;
          res_d.event_code   = EV_DATA_TMO;
          res_d.expired_seq  = tag_q[exp_idx];
          res_d.expired_slot = exp_slot;
        end
      end
      MODE_START: begin
        if (slot_ok) begin
          dl_d[start_idx]  = start_dl;
          tag_d[start_idx] = req_q.seq_number;
          ofs_d            = ofs_bump;
          recompute        = 1'b1;
        end
      end
      MODE_STOP: begin
        recompute = 1'b1;
        if (stop_hit) begin
          dl_d[stop_idx]  = '0;
          tag_d[stop_idx] = '1;
        end else begin
          res_d.stop_missed = 1'b1;
        end
      end
      MODE_ACK_START: begin
        ack_d = ack_start_dl;
        ofs_d = ofs_bump;
      end
      MODE_ACK_STOP: begin
        ack_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Min tree over the updated bank; an off slot counts as the all-ones time
  always_comb begin
    for (int n = 0; n < LEAVES; n++) begin
      if (n < SLOTS && dl_d[n] != '0) tree[LEAVES + n] = dl_d[n];
      else tree[LEAVES + n] = '1;
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      tree[n] = (tree[2*n+1] < tree[2*n]) ? tree[2*n+1] : tree[2*n];
    end
  end

  assign earliest_d = recompute ? tree[1] : earliest_q;

`ifndef SYNTHESIS
  a_missed_only_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.stop_missed |-> res_q.event_code == EV_NONE)
    else $error("stop miss reported together with an event");

  a_start_sets_earliest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && req_q.mode == MODE_START && slot_ok |=> earliest_q != '0)
    else $error("earliest deadline not set after a slot start");

  a_pick_clears_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && req_q.mode == MODE_PICK |=> ofs_q == '0)
    else $error("start offset not cleared by a pick");

  a_ack_tmo_clears_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_d.event_code == EV_ACK_TMO |=> ack_q == '0)
    else $error("ack timer still running after its timeout was reported");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while both stages are held");
`endif

endmodule

// ===== sim/timer_bank_checker.sv =====
`timescale 1ns / 1ps

module timer_bank_checker
  import rtbep_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration channel
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [IVAL_W-1:0]     cfg_data_i,
  // request stream
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  // now, seq_number, slot_index, frame_waiting, net_ready, zero fill
  input  logic [IN_DATA_W-1:0]  req_data_i,
  // mode
  input  logic [MODE_W-1:0]     req_user_i,
  // result stream
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  // expired_seq, expired_slot, stop_missed, zero fill
  input  logic [OUT_DATA_W-1:0] res_data_i,
  // event_code
  input  logic [CODE_W-1:0]     res_user_i,
  output int                    errors_o,
  output int                    pending_o
);

  // Shadow copy of the timer bank
  logic [TIME_BITS-1:0] slot_due [SLOTS];
  logic [SEQ_BITS-1:0]  slot_seq [SLOTS];
  logic [TIME_BITS-1:0] ack_due;
  logic [TIME_BITS-1:0] earliest_due;
  logic [OFS_W-1:0]     start_bump;
  logic [IVAL_W-1:0]    interval;

  res_t expected_events [$];
  int   error_count;

  // Clamp at the all-ones time instead of wrapping
  function automatic logic [TIME_BITS-1:0] clamp_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
    if (b > ~a) return '1;
    return a + b;
  endfunction

  // Lowest live deadline, all ones when the bank is empty
  function void refresh_earliest();
    logic [TIME_BITS-1:0] t;
    t = '1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_due[i] != '0 && slot_due[i] < t) t = slot_due[i];
    end
    earliest_due = t;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Run one request against the shadow bank and produce its event
  task automatic apply_timer_request(input req_t r, output res_t ev);
    logic hit;
    ev  = '0;
    hit = 1'b0;
    case (r.mode)
      MODE_PICK: begin
        start_bump = '0;
        if (ack_due != '0 && r.now >= ack_due) begin
          ack_due = '0;
          ev.event_code = EV_ACK_TMO;
        end else if (r.frame_waiting) begin
          ev.event_code = EV_FRAME;
        end else if (r.net_ready) begin
          ev.event_code = EV_NET_READY;
        end else if (earliest_due != '0 && r.now >= earliest_due) begin
          // ties go to the lowest index
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && slot_due[i] != '0 && slot_due[i] == earliest_due) begin
              hit = 1'b1;
              slot_due[i] = '0;
              ev.event_code   = EV_DATA_TMO;
              ev.expired_seq  = slot_seq[i];
              ev.expired_slot = SLOT_W'(i);
            end
          end
          if (hit) refresh_earliest();
        end
      end
      MODE_START: begin
        if (r.slot_index < SLOTS) begin
          slot_due[r.slot_index] = clamp_add(clamp_add(r.now, TIME_BITS'(interval)),
                                             TIME_BITS'(start_bump));
          slot_seq[r.slot_index] = r.seq_number;
          if (start_bump != OFS_MAX) start_bump++;
          refresh_earliest();
        end
      end
      MODE_STOP: begin
        ev.stop_missed = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && slot_seq[i] == r.seq_number) begin
            hit = 1'b1;
            slot_due[i] = '0;
            slot_seq[i] = '1;
            ev.stop_missed = 1'b0;
          end
        end
        refresh_earliest();
      end
      MODE_ACK_START: begin
        ack_due = clamp_add(r.now, TIME_BITS'(interval >> 1));
        if (start_bump != OFS_MAX) start_bump++;
      end
      MODE_ACK_STOP: ack_due = '0;
      default: ;
    endcase
  endtask

  // Watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    req_t r;
    res_t ev;
    res_t got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_due[i] = '0;
        slot_seq[i] = '1;
      end
      ack_due      = '0;
      earliest_due = '0;
      start_bump   = '0;
      interval     = IVAL_RESET;
      expected_events.delete();
      error_count  = 0;
      errors_o    <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) interval = cfg_data_i;

      if (res_valid_i && res_ready_i) begin
        got.event_code   = res_user_i;
        got.expired_seq  = res_data_i[SEQ_BITS-1:0];
        got.expired_slot = res_data_i[SEQ_BITS +: SLOT_W];
        got.stop_missed  = res_data_i[SEQ_BITS+SLOT_W];
        if (expected_events.size() == 0) begin
          report_mismatch("unrequested result", 32'(got), 32'd0);
        end else begin
          ev = expected_events.pop_front();
          if (got.event_code != ev.event_code)
            report_mismatch("event_code", 32'(got.event_code), 32'(ev.event_code));
          if (got.expired_seq != ev.expired_seq)
            report_mismatch("expired_seq", 32'(got.expired_seq), 32'(ev.expired_seq));
          if (got.expired_slot != ev.expired_slot)
            report_mismatch("expired_slot", 32'(got.expired_slot), 32'(ev.expired_slot));
          if (got.stop_missed != ev.stop_missed)
            report_mismatch("stop_missed", 32'(got.stop_missed), 32'(ev.stop_missed));
        end
      end

      if (req_valid_i && req_ready_i) begin
        r.mode          = req_user_i;
        r.now           = req_data_i[TIME_BITS-1:0];
        r.seq_number    = req_data_i[TIME_BITS +: SEQ_BITS];
        r.slot_index    = req_data_i[TIME_BITS+SEQ_BITS +: SLOT_W];
        r.frame_waiting = req_data_i[TIME_BITS+SEQ_BITS+SLOT_W];
        r.net_ready     = req_data_i[TIME_BITS+SEQ_BITS+SLOT_W+1];
        apply_timer_request(r, ev);
        expected_events.push_back(ev);
      end

      errors_o  <= error_count;
      pending_o <= expected_events.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import rtbep_pkg::*;

  localparam int unsigned NUM_SLOTS = 8;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [IVAL_W-1:0]     cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [CODE_W-1:0]     m_axis_tuser;

  int pending_cnt;
  int error_cnt;

  // stimulus state
  logic                 calm = 1'b0;
  int                   stall_left = 0;
  logic [TIME_BITS-1:0] sim_clock;
  logic [IVAL_W-1:0]    cur_interval;
  logic [SEQ_BITS-1:0]  started_tag [NUM_SLOTS];

  retransmit_timer_bank_event_picker #(.SLOTS(NUM_SLOTS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  timer_bank_checker #(.SLOTS(NUM_SLOTS)) event_watch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_user_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_user_i  (m_axis_tuser),
    .errors_o    (error_cnt),
    .pending_o   (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stall bursts, always ready once calm
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // One request, with an occasional idle burst ahead of it
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [TIME_BITS-1:0] now,
                              input logic [SEQ_BITS-1:0] seq,
                              input logic [SLOT_W-1:0] slot,
                              input logic fw, input logic nr);
    int gap;
    if (!calm && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= IN_DATA_W'({nr, fw, slot, seq, now});
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == MODE_START) started_tag[slot] = seq;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [IVAL_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_interval = value;
  endtask

  // Random request around the running protocol clock
  task automatic random_item(input bit starts_only);
    int                   roll;
    logic [TIME_BITS-1:0] advance;
    logic [MODE_W-1:0]    mode;
    logic [TIME_BITS-1:0] now;
    logic [SEQ_BITS-1:0]  seq;
    logic [SLOT_W-1:0]    slot;
    advance = $urandom_range(0, cur_interval / 8 + 1);
    if (advance > ~sim_clock) sim_clock = '1;
    else sim_clock = sim_clock + advance;

    roll = $urandom_range(0, 99);
    if (starts_only) begin
      if (roll < 85)      mode = MODE_START;
      else if (roll < 95) mode = MODE_STOP;
      else                mode = MODE_ACK_START;
    end else begin
      if (roll < 40)      mode = MODE_PICK;
      else if (roll < 68) mode = MODE_START;
      else if (roll < 82) mode = MODE_STOP;
      else if (roll < 89) mode = MODE_ACK_START;
      else if (roll < 94) mode = MODE_ACK_STOP;
      else                mode = MODE_W'($urandom_range(int'(MODE_ACK_STOP) + 1,
                                                        (1 << MODE_W) - 1));
    end

    now  = ($urandom_range(0, 99) < 8) ? TIME_BITS'($urandom()) : sim_clock;
    slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    seq  = SEQ_BITS'($urandom_range(0, 16'hFFFE));
    if (mode == MODE_STOP) begin
      roll = $urandom_range(0, 9);
      if (roll < 6)      seq = started_tag[SLOT_W'($urandom_range(0, NUM_SLOTS - 1))];
      else if (roll < 9) seq = SEQ_BITS'($urandom_range(0, 16'hFFFF));
      else               seq = '1;
    end
    send_request(mode, now, seq, slot, $urandom_range(0, 7) == 0,
                 $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [IVAL_W-1:0] phase_ival;
    int                phase_len;
    for (int i = 0; i < NUM_SLOTS; i++) started_tag[i] = '1;
    cur_interval = IVAL_RESET;
    sim_clock    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset interval
    send_request(MODE_PICK, 32'd0, 16'd0, 3'd0, 1'b0, 1'b0);         // empty bank
    send_request(MODE_STOP, 32'd0, 16'hFFFF, 3'd0, 1'b0, 1'b0);      // hits idle slot
    send_request(MODE_STOP, 32'd0, 16'h1234, 3'd0, 1'b0, 1'b0);      // missed
    send_request(MODE_START, 32'd0, 16'h0000, 3'd0, 1'b0, 1'b0);
    send_request(MODE_START, 32'd0, 16'hFFFE, 3'd7, 1'b1, 1'b1);
    send_request(MODE_START, 32'hFFFF_FFF0, 16'h5555, 3'd3, 1'b0, 1'b0); // clamps
    send_request(MODE_ACK_START, 32'd10, 16'd0, 3'd0, 1'b0, 1'b0);
    send_request(MODE_PICK, 32'd50, 16'd0, 3'd0, 1'b1, 1'b1);        // frame wins
    send_request(MODE_PICK, 32'd60, 16'd0, 3'd0, 1'b1, 1'b1);        // ack wins
    send_request(MODE_PICK, 32'd70, 16'd0, 3'd0, 1'b0, 1'b1);        // net ready
    send_request(MODE_PICK, 32'd99, 16'd0, 3'd0, 1'b0, 1'b0);        // not yet due
    send_request(MODE_PICK, 32'd100, 16'd0, 3'd0, 1'b0, 1'b0);       // slot 0 expires
    send_request(MODE_STOP, 32'd100, 16'h0000, 3'd0, 1'b0, 1'b0);    // tag kept after expiry
    send_request(MODE_PICK, 32'h7FFF_FFFF, 16'd0, 3'd0, 1'b0, 1'b0);
    send_request(MODE_PICK, 32'hFFFF_FFFF, 16'd0, 3'd0, 1'b0, 1'b0);
    send_request(MODE_PICK, 32'hFFFF_FFFF, 16'd0, 3'd0, 1'b0, 1'b0); // nothing left
    send_request(MODE_START, 32'd500, 16'hAAAA, 3'd2, 1'b0, 1'b0);
    send_request(MODE_START, 32'd499, 16'h0F0F, 3'd5, 1'b0, 1'b0);   // same deadline
    send_request(MODE_ACK_START, 32'd500, 16'd0, 3'd0, 1'b0, 1'b0);
    send_request(MODE_ACK_STOP, 32'd500, 16'd0, 3'd0, 1'b0, 1'b0);
    for (int m = int'(MODE_ACK_STOP) + 1; m < (1 << MODE_W); m++)
      send_request(MODE_W'(m), TIME_BITS'($urandom()), SEQ_BITS'($urandom()),
                   SLOT_W'($urandom()), 1'b1, 1'b1);
    send_request(MODE_PICK, 32'd600, 16'd0, 3'd0, 1'b0, 1'b0);       // lower index first
    send_request(MODE_PICK, 32'd600, 16'd0, 3'd0, 1'b0, 1'b0);

    // Random phases, one interval setting each
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: begin phase_ival = 16'd1;     sim_clock = $urandom_range(0, 1 << 20); end
        1: begin phase_ival = 16'd0;     sim_clock = '0; end
        2: begin phase_ival = 16'hFFFF;  sim_clock = $urandom() & 32'h7FFF_FFFF; end
        3: begin phase_ival = IVAL_RESET; sim_clock = 32'hFFFF_FFFF - 32'd1000; end
        default: begin
          phase_ival = IVAL_W'($urandom_range(2, 2000));
          sim_clock  = $urandom();
          calm <= 1'b1;
        end
      endcase
      write_interval(phase_ival);
      phase_len = (p == 0) ? 300 : 225;

      // zero interval: a start at time zero right after a pick stays off
      if (p == 1) begin
        send_request(MODE_PICK, 32'd0, 16'd0, 3'd0, 1'b0, 1'b0);
        send_request(MODE_START, 32'd0, 16'h0001, 3'd1, 1'b0, 1'b0);
      end

      for (int k = 0; k < phase_len; k++) begin
        if (p == 0 && k == 150) wait_drained();
        // long run without picks lets the start offset climb toward saturation
        random_item(p == 0 && k < 280);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rtbep_pkg.sv
design/retransmit_timer_bank_event_picker.sv
sim/timer_bank_checker.sv
sim/testbench.sv
